FILE: sv/pid_pkg.sv
package pid_pkg;

  localparam int GAIN_W     = 16;
  localparam int VAL_W      = 16;
  localparam int ERR_W      = VAL_W + 1;
  localparam int PRIOR_W    = VAL_W + 2;
  localparam int TOTAL_W    = 32;
  localparam int MUL_B_W    = TOTAL_W + 1;
  localparam int PROD_W     = GAIN_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int DRIVE_W    = 48;
  localparam int TIME_W     = 16;
  localparam int DIVD_W     = GAIN_W + PRIOR_W;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd2;

  // Input operations
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Datapath commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_NONE     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MUL_P    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_MUL_I    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MUL_D    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DIV_LOAD = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DIV_STEP = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ADD_Q    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_EMIT     = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

FILE: sv/pid_in_if.sv
interface pid_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [pid_pkg::VAL_W-1:0]    target_value;
  logic signed [pid_pkg::VAL_W-1:0]    measured_value;
  logic        [pid_pkg::TIME_W-1:0]   elapsed_ms;

  modport source (
    output valid, operation, target_value, measured_value, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, target_value, measured_value, elapsed_ms,
    output ready
  );
endinterface

FILE: sv/pid_out_if.sv
interface pid_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pid_pkg::DRIVE_W-1:0]  drive_value;
  logic                                saturated;

  modport source (
    output valid, drive_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, drive_value, saturated,
    output ready
  );
endinterface

FILE: sv/pid_ctrl.sv
module pid_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  output pid_pkg::ctrl_cmd_t   cmd,
  input  pid_pkg::dp_status_t  status
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_P    = 3'd1;
  localparam logic [2:0] S_MUL_I    = 3'd2;
  localparam logic [2:0] S_MUL_D    = 3'd3;
  localparam logic [2:0] S_DIV_LOAD = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_ADD_Q    = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  localparam logic [pid_pkg::CNT_W-1:0] DIV_LAST = pid_pkg::CNT_W'(pid_pkg::DIV_STEPS - 1);

  logic [2:0]                state, state_next;
  logic [pid_pkg::CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = pid_pkg::CMD_NONE;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == pid_pkg::OP_CLEAR) begin
            cmd.op = pid_pkg::CMD_CLEAR;
          end else begin
            cmd.op     = pid_pkg::CMD_LOAD;
            state_next = S_MUL_P;
          end
        end
      end
      S_MUL_P: begin
        cmd.op     = pid_pkg::CMD_MUL_P;
        state_next = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.op     = pid_pkg::CMD_MUL_I;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op     = pid_pkg::CMD_MUL_D;
        state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        cmd.op     = pid_pkg::CMD_DIV_LOAD;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = pid_pkg::CMD_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_ADD_Q;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ADD_Q: begin
        cmd.op     = pid_pkg::CMD_ADD_Q;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op     = pid_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == DIV_LAST) |=> (state == S_ADD_Q))
    else $error("divider did not hand over after its last step");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pid_pkg::CMD_EMIT) |-> !status.out_busy)
    else $error("result written over a word still waiting");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_DIV) |-> (cnt == '0))
    else $error("step count left running outside the divide");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_op == pid_pkg::OP_PROCESS) |=> (state == S_MUL_P))
    else $error("accepted sample did not start the sequence");
`endif

endmodule

FILE: sv/pid_dpath.sv
module pid_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pid_pkg::ctrl_cmd_t                   cmd,
  output pid_pkg::dp_status_t                  status,
  input  logic                                 cfg_wen,
  input  logic        [pid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pid_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic signed [pid_pkg::VAL_W-1:0]     target_value,
  input  logic signed [pid_pkg::VAL_W-1:0]     measured_value,
  input  logic        [pid_pkg::TIME_W-1:0]    elapsed_ms,
  output logic signed [pid_pkg::DRIVE_W-1:0]   drive_value,
  output logic                                 saturated,
  output logic                                 out_valid,
  input  logic                                 out_ready
);

  localparam int TW = pid_pkg::TOTAL_W;
  localparam int AW = pid_pkg::ACC_W;
  localparam int DW = pid_pkg::DRIVE_W;
  localparam logic signed [TW-1:0] TOTAL_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] TOTAL_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [DW-1:0] DRIVE_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DRIVE_MIN = {1'b1, {(DW-1){1'b0}}};

  logic signed [pid_pkg::GAIN_W-1:0]  kp, ki, kd;
  logic signed [TW-1:0]               error_total;
  logic signed [pid_pkg::PRIOR_W-1:0] prior_error;

  logic signed [pid_pkg::ERR_W-1:0]   err_r;
  logic signed [pid_pkg::PRIOR_W-1:0] delta_r;
  logic        [pid_pkg::TIME_W-1:0]  divisor_r;
  logic                               sat_r;
  logic signed [pid_pkg::PROD_W-1:0]  prod_r;
  logic signed [AW-1:0]               acc;
  logic        [pid_pkg::DIVD_W-1:0]  quo;
  logic        [pid_pkg::TIME_W-1:0]  rem;
  logic                               q_neg;

  logic signed [pid_pkg::ERR_W-1:0]   err_w;
  logic signed [TW:0]                 total_sum;
  logic                               total_ovf;
  logic signed [TW-1:0]               total_sat;
  logic signed [pid_pkg::GAIN_W-1:0]  mul_a;
  logic signed [pid_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pid_pkg::PROD_W-1:0]  prod_w;
  logic        [pid_pkg::TIME_W:0]    shift_w;
  logic        [pid_pkg::TIME_W:0]    diff_w;
  logic                               fits;
  logic signed [pid_pkg::DIVD_W:0]    q_signed;
  logic                               drive_ovf;
  logic signed [DW-1:0]               drive_sat;

  // Error and saturating running total
  assign err_w     = pid_pkg::ERR_W'(target_value) - pid_pkg::ERR_W'(measured_value);
  assign total_sum = (TW+1)'(error_total) + (TW+1)'(err_w);
  assign total_ovf = total_sum[TW] != total_sum[TW-1];
  assign total_sat = total_ovf ? (total_sum[TW] ? TOTAL_MIN : TOTAL_MAX) : total_sum[TW-1:0];

  // Shared multiplier
  always_comb begin
    unique case (cmd.op)
      pid_pkg::CMD_MUL_P: begin
        mul_a = kp;
        mul_b = pid_pkg::MUL_B_W'(err_r);
      end
      pid_pkg::CMD_MUL_I: begin
        mul_a = ki;
        mul_b = pid_pkg::MUL_B_W'(error_total);
      end
      default: begin
        mul_a = kd;
        mul_b = pid_pkg::MUL_B_W'(delta_r);
      end
    endcase
  end
  assign prod_w = mul_a * mul_b;

  // One restoring divide step
  assign shift_w = {rem, quo[pid_pkg::DIVD_W-1]};
  assign fits    = shift_w >= {1'b0, divisor_r};
  assign diff_w  = shift_w - {1'b0, divisor_r};

  assign q_signed = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // Output clamp
  assign drive_ovf = !((acc[AW-1:DW-1] == '0) || (acc[AW-1:DW-1] == '1));
  assign drive_sat = drive_ovf ? (acc[AW-1] ? DRIVE_MIN : DRIVE_MAX) : acc[DW-1:0];

  assign status.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= '0;
      ki          <= '0;
      kd          <= '0;
      error_total <= '0;
      prior_error <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          pid_pkg::REG_KP: kp <= cfg_data;
          pid_pkg::REG_KI: ki <= cfg_data;
          pid_pkg::REG_KD: kd <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == pid_pkg::CMD_CLEAR) begin
        error_total <= '0;
        prior_error <= '0;
      end else if (cmd.op == pid_pkg::CMD_LOAD) begin
        error_total <= total_sat;
        prior_error <= pid_pkg::PRIOR_W'(err_w);
      end
      if (cmd.op == pid_pkg::CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pid_pkg::CMD_LOAD: begin
        err_r     <= err_w;
        delta_r   <= pid_pkg::PRIOR_W'(err_w) - prior_error;
        divisor_r <= (elapsed_ms == '0) ? pid_pkg::TIME_W'(1) : elapsed_ms;
        sat_r     <= total_ovf;
      end
      pid_pkg::CMD_MUL_P: begin
        prod_r <= prod_w;
      end
      pid_pkg::CMD_MUL_I: begin
        prod_r <= prod_w;
        acc    <= AW'(prod_r);
      end
      pid_pkg::CMD_MUL_D: begin
        prod_r <= prod_w;
        acc    <= acc + AW'(prod_r);
      end
      pid_pkg::CMD_DIV_LOAD: begin
        q_neg <= prod_r[pid_pkg::PROD_W-1];
        rem   <= '0;
        if (prod_r[pid_pkg::PROD_W-1]) begin
          quo <= pid_pkg::DIVD_W'(-prod_r);
        end else begin
          quo <= prod_r[pid_pkg::DIVD_W-1:0];
        end
      end
      pid_pkg::CMD_DIV_STEP: begin
        rem <= fits ? diff_w[pid_pkg::TIME_W-1:0] : shift_w[pid_pkg::TIME_W-1:0];
        quo <= {quo[pid_pkg::DIVD_W-2:0], fits};
      end
      pid_pkg::CMD_ADD_Q: begin
        acc <= acc + AW'(q_signed);
      end
      pid_pkg::CMD_EMIT: begin
        drive_value <= drive_sat;
        saturated   <= sat_r | drive_ovf;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/pid_controller_step_top.sv
// Discrete PID step: drive = kp*err + ki*total + kd*(err - prior)/elapsed, Q.8, 48-bit clamp.
// An accepted sample word steps through MUL_P, MUL_I, MUL_D, DIV_LOAD, DIV, ADD_Q and EMIT.
// Process words are taken one at a time: the next is accepted only after the 34-step serial
// divider for the derivative term ends and the result is emitted; a clear word gives no result.
// A finished word waits in the output register while the next sample is taken.
// Reset (rst, synchronous, active high) zeroes the gains, total and prior error.
module pid_controller_step_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic        [pid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pid_pkg::CFG_DATA_W-1:0] cfg_data,
  pid_in_if.sink                                sample,
  pid_out_if.source                             drive
);

  // Command and status between sequencer and datapath
  pid_pkg::ctrl_cmd_t  cmd;
  pid_pkg::dp_status_t status;

  // Sequencer: takes sample words in idle, steps the multiplier and divider,
  // and holds the result until the output register frees up.
  pid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_op    (sample.operation),
    .in_ready (sample.ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath: gains, running total, prior error, shared 16x33 multiplier,
  // restoring divider, accumulator and output register.
  pid_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .target_value   (sample.target_value),
    .measured_value (sample.measured_value),
    .elapsed_ms     (sample.elapsed_ms),
    .drive_value    (drive.drive_value),
    .saturated      (drive.saturated),
    .out_valid      (drive.valid),
    .out_ready      (drive.ready)
  );

endmodule
